// ===== design/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP string matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int LEN_W       = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int BYTE_W      = 8;
    localparam int BYTES_PER_REG = 8;
    localparam int OUT_POS_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_0_7   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_8_15  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_16_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_24_31 = 3'd4;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic                 en;
        logic [PAT_IDX_W-1:0] addr;
        logic [PAT_IDX_W-1:0] data;
    } ft_wr_t;

endpackage

// ===== design/kmp_pattern_store.sv =====
// Pattern configuration registers with a single byte read port.
// Depends on kmp_pkg; clamps the configured length to the pattern depth.
`timescale 1ns / 1ps

module kmp_pattern_store import kmp_pkg::*; #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_wr_t              cfg_wr,
    input  logic [PAT_IDX_W-1:0] rd_addr,
    output logic [BYTE_W-1:0]    rd_byte,
    output logic [LEN_W-1:0]     act_len
);

    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] pat_reg [PAT_BYTES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_W'(1);
            for (int b = 0; b < PAT_BYTES; b++) begin
                pat_reg[b] <= '0;
            end
        end else if (cfg_wr.en) begin
            unique case (cfg_wr.idx)
                REG_PATTERN_LENGTH: begin
                    len_reg <= cfg_wr.data[LEN_W-1:0];
                end
                REG_PATTERN_BYTES_0_7, REG_PATTERN_BYTES_8_15,
                REG_PATTERN_BYTES_16_23, REG_PATTERN_BYTES_24_31: begin
                    for (int b = 0; b < BYTES_PER_REG; b++) begin
                        pat_reg[PAT_IDX_W'((int'(cfg_wr.idx) - 1) * BYTES_PER_REG + b)]
                            <= cfg_wr.data[b*BYTE_W +: BYTE_W];
                    end
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign rd_byte = pat_reg[rd_addr];
    assign act_len = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

endmodule

// ===== design/kmp_fail_table.sv =====
// Failure table storage: one write port, one combinational read port.
// Depends on kmp_pkg; entry zero always reads as zero.
`timescale 1ns / 1ps

module kmp_fail_table import kmp_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic                 aclk,
    input  ft_wr_t               ft_wr,
    input  logic [PAT_IDX_W-1:0] rd_addr,
    output logic [PAT_IDX_W-1:0] rd_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PAT_IDX_W-1:0] ft_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (ft_wr.en) begin
            ft_reg[ft_wr.addr[IDX_W-1:0]] <= ft_wr.data;
        end
    end

    assign rd_data = (rd_addr == '0) ? '0 : ft_reg[rd_addr[IDX_W-1:0]];

endmodule

// ===== design/kmp_stream_string_match.sv =====
// Streaming KMP matcher top level: sequencer, position counter, result register.
// Depends on kmp_pkg, kmp_pattern_store and kmp_fail_table.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tdata: text_byte; tuser: first_of_text
//  m_      | out | m_tvalid/m_tready | tdata: match_position; tuser: match_found
//  cfg_    | in  | cfg_wr_en         | cfg_addr, cfg_wr_data
//
// Each byte is taken in ST_IDLE, then compared in ST_MATCH once per failure-table step
// through the shared byte comparator; a full output register holds it in ST_MATCH.
// A register write restarts the table build through ST_LOAD and ST_CMP; s_tready
// stays low meanwhile. Reset holds a length of one, whose table needs no build.
// A finished result waits in the output register while the next byte is taken.
`timescale 1ns / 1ps

module kmp_stream_string_match import kmp_pkg::*; #(
    parameter int MAX_PATTERN    = 32,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // [0] first_of_text
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] match_position
    output logic                  m_tuser,   // [0] match_found
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SUM_W = (POSITION_WIDTH > OUT_POS_W) ? POSITION_WIDTH : OUT_POS_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_MATCH = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          i_reg, i_next;
    logic [PAT_IDX_W-1:0]      k_reg, k_next;
    logic [LEN_W-1:0]          mlen_reg, mlen_next;
    logic [BYTE_W-1:0]         cur_reg, cur_next;
    logic [BYTE_W-1:0]         byte_reg, byte_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic                      mv_reg, mv_next;
    logic                      mf_reg, mf_next;
    logic [OUT_POS_W-1:0]      mp_reg, mp_next;

    cfg_wr_t              cfg_wr;
    ft_wr_t               ft_wr;
    logic                 cfg_hit;
    logic [PAT_IDX_W-1:0] pat_addr;
    logic [BYTE_W-1:0]    pat_byte;
    logic [LEN_W-1:0]     act_len;
    logic [PAT_IDX_W-1:0] ft_addr;
    logic [PAT_IDX_W-1:0] ft_data;
    logic                 eq;
    logic                 accept;
    logic                 out_free;
    logic [LEN_W-1:0]     mlen_inc;
    logic [POSITION_WIDTH-1:0] pos_base;
    logic [SUM_W-1:0]     start_pos;

    assign cfg_hit = cfg_wr_en && (cfg_addr <= REG_PATTERN_BYTES_24_31);
    assign cfg_wr  = '{en: cfg_wr_en, idx: cfg_addr, data: cfg_wr_data};

    kmp_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_pattern (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .rd_addr (pat_addr),
        .rd_byte (pat_byte),
        .act_len (act_len)
    );

    kmp_fail_table #(
        .DEPTH (MAX_PATTERN)
    ) u_fail (
        .aclk    (aclk),
        .ft_wr   (ft_wr),
        .rd_addr (ft_addr),
        .rd_data (ft_data)
    );

    assign s_tready = (state_reg == ST_IDLE) && !cfg_hit;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;

    // shared byte comparator
    assign eq = (pat_byte == ((state_reg == ST_MATCH) ? byte_reg : cur_reg));

    assign mlen_inc  = mlen_reg + LEN_W'(1);
    assign pos_base  = s_tuser ? '0 : pos_reg;
    assign start_pos = SUM_W'(pos_reg) - SUM_W'(act_len) + SUM_W'(1);

    always_comb begin
        unique case (state_reg)
            ST_LOAD:  pat_addr = i_reg[PAT_IDX_W-1:0];
            ST_CMP:   pat_addr = k_reg;
            default:  pat_addr = mlen_reg[PAT_IDX_W-1:0];
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_CMP:   ft_addr = k_reg - PAT_IDX_W'(1);
            ST_MATCH: ft_addr = eq ? PAT_IDX_W'(act_len - LEN_W'(1))
                                   : PAT_IDX_W'(mlen_reg - LEN_W'(1));
            default:  ft_addr = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        mlen_next  = mlen_reg;
        cur_next   = cur_reg;
        byte_next  = byte_reg;
        pos_next   = pos_reg;
        mv_next    = mv_reg && !m_tready;
        mf_next    = mf_reg;
        mp_next    = mp_reg;
        ft_wr      = '{en: 1'b0, addr: i_reg[PAT_IDX_W-1:0], data: '0};

        if (cfg_hit) begin
            // restart the table build on any write to the length or pattern-byte registers
            state_next = ST_LOAD;
            i_next     = LEN_W'(1);
            k_next     = '0;
            mlen_next  = '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        byte_next  = s_tdata;
                        pos_next   = (pos_base == '1) ? pos_base
                                                      : pos_base + POSITION_WIDTH'(1);
                        if (s_tuser) begin
                            mlen_next = '0;
                        end
                        state_next = ST_MATCH;
                    end
                end
                ST_LOAD: begin
                    if (i_reg >= act_len) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = pat_byte;
                        state_next = ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (eq) begin
                        ft_wr.en   = 1'b1;
                        ft_wr.data = k_reg + PAT_IDX_W'(1);
                        k_next     = k_reg + PAT_IDX_W'(1);
                        i_next     = i_reg + LEN_W'(1);
                        state_next = ST_LOAD;
                    end else if (k_reg != '0) begin
                        k_next = ft_data;
                    end else begin
                        ft_wr.en   = 1'b1;
                        i_next     = i_reg + LEN_W'(1);
                        state_next = ST_LOAD;
                    end
                end
                ST_MATCH: begin
                    if (act_len != '0 && !eq && mlen_reg != '0) begin
                        mlen_next = LEN_W'(ft_data);
                    end else if (out_free) begin
                        mv_next    = 1'b1;
                        state_next = ST_IDLE;
                        if (act_len == '0) begin
                            mlen_next = '0;
                            mf_next   = 1'b0;
                            mp_next   = '0;
                        end else if (eq && mlen_inc >= act_len) begin
                            mlen_next = LEN_W'(ft_data);
                            mf_next   = 1'b1;
                            mp_next   = start_pos[OUT_POS_W-1:0];
                        end else begin
                            mlen_next = eq ? mlen_inc : mlen_reg;
                            mf_next   = 1'b0;
                            mp_next   = '0;
                        end
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
            mlen_reg  <= '0;
            pos_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            mlen_reg  <= mlen_next;
            pos_reg   <= pos_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        mf_reg   <= mf_next;
        mp_reg   <= mp_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mf_reg;
    assign m_tdata  = mp_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input taken again before the byte was processed");

    a_no_pos_without_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("start position reported without a match");

    a_progress_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && act_len != '0) |-> (mlen_reg < act_len))
        else $error("match progress reached the pattern length while idle");

    a_result_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH && state_next == ST_IDLE && !cfg_hit) |=> m_tvalid)
        else $error("finished byte produced no result");

endmodule
